### rtl/core/aes_cfb_block_decryptor_assert.svh
// Assertion macros shared by the checker of the CFB decryptor.
// No dependencies.
`ifndef AES_CFB_BLOCK_DECRYPTOR_ASSERT_SVH
`define AES_CFB_BLOCK_DECRYPTOR_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define ACB_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define ACB_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

### rtl/core/acbd_pkg.sv
// Package for the AES-CFB block decryptor: constants, types, S-box and round functions.
// Used by acbd_round, acbd_seq, the top level and the checker; no dependencies.
`default_nettype none
package acbd_pkg;
  localparam int KeyHalfSlots = 30;
  localparam int SlotW = $clog2(KeyHalfSlots);

  localparam logic [1:0] ReqKey = 2'd0;
  localparam logic [1:0] ReqIv = 2'd1;
  localparam logic [1:0] ReqData = 2'd2;

  localparam logic [3:0] RoundsMin = 4'd10;
  localparam logic [3:0] RoundsMax = 4'd14;

  typedef enum logic [2:0] {
    ST_IDLE, ST_KEY0, ST_KEY1, ST_ROUND, ST_OUT
  } state_t;

  // Control from the sequencer to the round datapath.
  typedef struct packed {
    logic load;      // State takes chain XOR round key 0.
    logic step;      // Apply one round with the current key.
    logic last;      // Final round: no MixColumns.
  } rnd_ctrl_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] r;
    case (x)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of the state sits at bits 8i+7:8i; byte index = row + 4 * column.
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[8*(r+4*c) +: 8] = sbox(s[8*(r+4*((c+r)%4)) +: 8]);
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = s[32*c +: 8];
      a1 = s[32*c+8 +: 8];
      a2 = s[32*c+16 +: 8];
      a3 = s[32*c+24 +: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      t[32*c +: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      t[32*c+8 +: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      t[32*c+16 +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      t[32*c+24 +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  // Byte mask for the first n bytes of a 128-bit block, n in 0..16.
  function automatic logic [127:0] byte_mask(input logic [4:0] n);
    logic [127:0] m;
    for (int i = 0; i < 16; i++) begin
      m[8*i +: 8] = (5'(i) < n) ? 8'hff : 8'h00;
    end
    return m;
  endfunction
endpackage
`default_nettype wire

### rtl/core/acbd_ram.sv
// Generic RAM with one write port and a registered read port, each with its own address.
// No dependencies.
`default_nettype none
module acbd_ram #(
  parameter int Width = 64,
  parameter int Depth = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/core/acbd_round.sv
// Shared AES round unit: holds the cipher state and applies one round per step.
// Depends on acbd_pkg.
`default_nettype none
module acbd_round (
  input  wire logic               clk,
  input  wire acbd_pkg::rnd_ctrl_t ctrl,
  input  wire logic [127:0]       chain,
  input  wire logic [127:0]       rkey,
  output      logic [127:0]       state
);
  logic [127:0] sub;
  logic [127:0] mixed;

  assign sub = acbd_pkg::sub_shift(state);
  assign mixed = ctrl.last ? sub : acbd_pkg::mix_columns(sub);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      state <= chain ^ rkey;
    end else if (ctrl.step) begin
      state <= mixed ^ rkey;
    end
  end
endmodule
`default_nettype wire

### rtl/core/acbd_seq.sv
// Sequencer: accepts items, fetches key halves from the store, runs the rounds.
// Depends on acbd_pkg.
`default_nettype none
module acbd_seq (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_take,
  input  wire logic                        is_data,
  input  wire logic [3:0]                  rounds,
  input  wire logic                        out_free,
  output      logic                        busy,
  output      logic                        out_load,
  output      logic [acbd_pkg::SlotW-1:0]  key_addr,
  output      logic                        key_lo_we,
  output      acbd_pkg::rnd_ctrl_t         ctrl
);
  acbd_pkg::state_t state, state_next;
  logic [3:0] rnd, rnd_next;

  // The key read is registered: ST_KEY0 addresses the low half, ST_KEY1 the high half.
  always_comb begin
    state_next = state;
    rnd_next = rnd;
    case (state)
      acbd_pkg::ST_IDLE: begin
        if (in_take && is_data) begin
          state_next = acbd_pkg::ST_KEY0;
          rnd_next = 4'd0;
        end
      end
      acbd_pkg::ST_KEY0: state_next = acbd_pkg::ST_KEY1;
      acbd_pkg::ST_KEY1: state_next = acbd_pkg::ST_ROUND;
      acbd_pkg::ST_ROUND: begin
        if (rnd == rounds) begin
          state_next = acbd_pkg::ST_OUT;
        end else begin
          rnd_next = rnd + 4'd1;
          state_next = acbd_pkg::ST_KEY0;
        end
      end
      acbd_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = acbd_pkg::ST_IDLE;
        end
      end
      default: state_next = acbd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b1;
    out_load = 1'b0;
    key_lo_we = 1'b0;
    ctrl = '0;
    key_addr = acbd_pkg::SlotW'({rnd, 1'b0});
    case (state)
      acbd_pkg::ST_IDLE: busy = 1'b0;
      acbd_pkg::ST_KEY0: busy = 1'b1;
      acbd_pkg::ST_KEY1: begin
        key_lo_we = 1'b1;
        key_addr = acbd_pkg::SlotW'({rnd, 1'b1});
      end
      acbd_pkg::ST_ROUND: begin
        ctrl.load = (rnd == 4'd0);
        ctrl.step = (rnd != 4'd0);
        ctrl.last = (rnd == rounds);
      end
      acbd_pkg::ST_OUT: out_load = out_free;
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= acbd_pkg::ST_IDLE;
      rnd <= 4'd0;
    end else begin
      state <= state_next;
      rnd <= rnd_next;
    end
  end
endmodule
`default_nettype wire

### rtl/core/aes_cfb_block_decryptor.sv
// AES-CFB-128 decryptor, one shared round unit stepped by a sequencer.
// A ciphertext block runs R rounds (10 to 14); before each round step the sequencer
// fetches both key halves, one after the other, from the key RAM.
// Key and IV loads leave the block idle. A result waits in an output register.
// Synchronous active-high reset clears the chain to zero and round_count to 10;
// the key store is not cleared and must be loaded before use.
`default_nettype none
module aes_cfb_block_decryptor (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [3:0]  cfg_data,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [4:0]  key_slot,
  input  wire logic [63:0] word_lo,
  input  wire logic [63:0] word_hi,
  input  wire logic [4:0]  byte_count,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [63:0] plain_lo,
  output      logic [63:0] plain_hi,
  output      logic [4:0]  valid_bytes
);
  logic [3:0] round_count;
  logic [3:0] rounds;
  logic busy, in_take, is_data, out_free, out_load, key_lo_we;
  logic [acbd_pkg::SlotW-1:0] key_addr, ram_addr;
  logic [63:0] key_rd, key_lo;
  logic [127:0] chain, cipher, mask, state;
  logic [4:0] count, n;
  logic key_we;
  acbd_pkg::rnd_ctrl_t ctrl;

  assign cfg_ready = 1'b1;
  assign in_stall = busy;
  assign in_take = in_valid && !busy;
  assign n = (byte_count > 5'd16) ? 5'd16 : byte_count;
  assign is_data = (req_type == acbd_pkg::ReqData) && (n != 5'd0);
  assign out_free = !out_valid || !out_stall;
  assign rounds = (round_count < acbd_pkg::RoundsMin) ? acbd_pkg::RoundsMin :
                  (round_count > acbd_pkg::RoundsMax) ? acbd_pkg::RoundsMax : round_count;
  assign key_we = in_take && (req_type == acbd_pkg::ReqKey) &&
                  (key_slot < 5'(acbd_pkg::KeyHalfSlots));
  assign ram_addr = key_we ? key_slot[acbd_pkg::SlotW-1:0] : key_addr;
  assign mask = acbd_pkg::byte_mask(count);

  acbd_ram #(.Width(64), .Depth(acbd_pkg::KeyHalfSlots)) u_keys (
    .clk(clk), .we(key_we), .waddr(key_slot[acbd_pkg::SlotW-1:0]), .wdata(word_lo),
    .raddr(ram_addr), .rdata(key_rd)
  );

  acbd_seq u_seq (
    .clk(clk), .rst(rst), .in_take(in_take), .is_data(is_data), .rounds(rounds),
    .out_free(out_free), .busy(busy), .out_load(out_load), .key_addr(key_addr),
    .key_lo_we(key_lo_we), .ctrl(ctrl)
  );

  acbd_round u_round (
    .clk(clk), .ctrl(ctrl), .chain(chain), .rkey({key_rd, key_lo}), .state(state)
  );

  always_ff @(posedge clk) begin
    if (key_lo_we) begin
      key_lo <= key_rd;
    end
    if (in_take && is_data) begin
      cipher <= {word_hi, word_lo} & acbd_pkg::byte_mask(n);
      count <= n;
    end
  end

  // The chain takes the masked ciphertext only when the result is handed on.
  always_ff @(posedge clk) begin
    if (rst) begin
      round_count <= 4'd10;
      chain <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        round_count <= cfg_data;
      end
      if (in_take && req_type == acbd_pkg::ReqIv) begin
        chain <= {word_hi, word_lo};
      end else if (out_load) begin
        chain <= cipher;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      {plain_hi, plain_lo} <= (cipher ^ state) & mask;
      valid_bytes <= count;
    end
  end
endmodule
`default_nettype wire

### rtl/core/acbd_checker.sv
// Port-level checker for the CFB decryptor, bound to the top level.
// Depends on aes_cfb_block_decryptor_assert.svh and acbd_pkg.
`default_nettype none
`include "aes_cfb_block_decryptor_assert.svh"
module acbd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  req_type,
  input wire logic [4:0]  byte_count,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] plain_lo,
  input wire logic [4:0]  valid_bytes
);
  `ACB_ASSERT_IMP(a_vb_range, clk, rst, out_valid, valid_bytes != 5'd0 && valid_bytes <= 5'd16, "valid_bytes out of range")
  `ACB_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(plain_lo), "stalled result changed")
  `ACB_ASSERT_NEXT(a_busy_after_data, clk, rst, in_valid && !in_stall && req_type == acbd_pkg::ReqData && byte_count != 5'd0, in_stall || out_valid, "block ciphertext transfer left no trace")
  `ACB_ASSERT_IMP(a_short_zero, clk, rst, out_valid && valid_bytes == 5'd1, plain_lo[63:8] == 56'd0, "unused plaintext bytes not zero")
endmodule

bind aes_cfb_block_decryptor acbd_checker u_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
  .byte_count(byte_count), .out_valid(out_valid), .out_stall(out_stall),
  .plain_lo(plain_lo), .valid_bytes(valid_bytes)
);
`default_nettype wire
